// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/lr_pkg.sv =====
// Package: types, widths and controller/datapath interface for the line rasterizer.
`default_nettype none

package lr_pkg;

   localparam int COORD_BITS = 6;
   localparam int FIELD_BITS = 6;
   localparam int ERR_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [FIELD_BITS-1:0]      field_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef struct packed {
      field_type x_start;
      field_type y_start;
      field_type x_end;
      field_type y_end;
   } lr_req_type;

   typedef struct packed {
      field_type point_x;
      field_type point_y;
      logic      last_point;
   } lr_rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic emit;
   } lr_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic last;
   } lr_sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/lr_dpath.sv =====
// Datapath: line setup, Bresenham step registers and the result register.
`default_nettype none

module lr_dpath (
   input  wire logic               clock,
   input  wire lr_pkg::lr_req_type req_data,
   input  wire lr_pkg::lr_cmd_type cmd,
   output lr_pkg::lr_sts_type      sts,
   output lr_pkg::lr_rsp_type      rsp_data
);

   lr_pkg::coord_type  major_pos_ff, major_pos_in;
   lr_pkg::coord_type  minor_pos_ff, minor_pos_in;
   lr_pkg::coord_type  major_end_ff, major_end_in;
   lr_pkg::coord_type  major_delta_ff, major_delta_in;
   lr_pkg::coord_type  minor_delta_ff, minor_delta_in;
   lr_pkg::err_type    error_ff, error_in;
   logic               steep_ff, steep_in;
   logic               down_ff, down_in;
   lr_pkg::lr_rsp_type rsp_ff, rsp_in;

   lr_pkg::coord_type x1, y1, x2, y2, dx, dy;
   lr_pkg::coord_type a1, b1, a2, b2, sa1, sb1, sa2, sb2;
   logic              steep_new, last;
   lr_pkg::err_type   err_sub;
   lr_pkg::coord_type px, py;

   // Setup from the request.
   always_comb begin
      x1 = req_data.x_start[lr_pkg::COORD_BITS-1:0];
      y1 = req_data.y_start[lr_pkg::COORD_BITS-1:0];
      x2 = req_data.x_end[lr_pkg::COORD_BITS-1:0];
      y2 = req_data.y_end[lr_pkg::COORD_BITS-1:0];
      dx = (x1 >= x2) ? x1 - x2 : x2 - x1;
      dy = (y1 >= y2) ? y1 - y2 : y2 - y1;
      steep_new = (dy > dx);
      if (steep_new) begin
         a1 = y1; b1 = x1; a2 = y2; b2 = x2;
      end else begin
         a1 = x1; b1 = y1; a2 = x2; b2 = y2;
      end
      if (a1 > a2) begin
         sa1 = a2; sb1 = b2; sa2 = a1; sb2 = b1;
      end else begin
         sa1 = a1; sb1 = b1; sa2 = a2; sb2 = b2;
      end
   end

   // One step of the walk.
   always_comb begin
      last    = (major_pos_ff == major_end_ff);
      err_sub = error_ff - lr_pkg::err_type'({minor_delta_ff, 1'b0});
      px      = steep_ff ? minor_pos_ff : major_pos_ff;
      py      = steep_ff ? major_pos_ff : minor_pos_ff;

      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_in       = error_ff;
      steep_in       = steep_ff;
      down_in        = down_ff;
      rsp_in         = rsp_ff;

      if (cmd.load) begin
         major_pos_in   = sa1;
         minor_pos_in   = sb1;
         major_end_in   = sa2;
         major_delta_in = sa2 - sa1;
         minor_delta_in = (sb1 >= sb2) ? sb1 - sb2 : sb2 - sb1;
         error_in       = lr_pkg::err_type'(sa2 - sa1);
         steep_in       = steep_new;
         down_in        = !(sb1 < sb2);
      end else if (cmd.emit) begin
         rsp_in.point_x    = lr_pkg::field_type'(px);
         rsp_in.point_y    = lr_pkg::field_type'(py);
         rsp_in.last_point = last;
         if (!last) begin
            if (err_sub < 0) begin
               minor_pos_in = down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
               error_in     = err_sub + lr_pkg::err_type'({major_delta_ff, 1'b0});
            end else begin
               error_in = err_sub;
            end
            major_pos_in = major_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      major_end_ff   <= major_end_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      error_ff       <= error_in;
      steep_ff       <= steep_in;
      down_ff        <= down_in;
      rsp_ff         <= rsp_in;
   end

   assign sts.last = last;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lr_ctrl.sv =====
// Controller: request/result handshakes and walk sequencing.
`default_nettype none
`include "assert_macros.svh"

module lr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire lr_pkg::lr_sts_type sts,
   output lr_pkg::lr_cmd_type      cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.emit  = (state_ff == ST_WALK) && slot_free;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (sts.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_load_busy, clock, reset, cmd.load, !req_ready)
   `ASSERT_NEXT(a_last_idle, clock, reset, cmd.emit && sts.last, req_ready)
   `ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid)
   `ASSERT_SAME(a_no_overlap, clock, reset, cmd.load, !cmd.emit)

endmodule

`default_nettype wire

// ===== rtl/core/line_rasterizer.sv =====
// Top level of the Bresenham line rasterizer: controller plus datapath.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    lr_req_type: x_start y_start x_end y_end
//   rsp      out  rsp_valid/rsp_ready    lr_rsp_type: point_x point_y last_point
//
// A line of N cells is set up at accept, then the walk loop emits one cell per
// cycle while rsp is not stalled, N = max(|dx|,|dy|) + 1, up to 64 cells.
// The output register is the only result storage; a stalled rsp holds the walk.
// The next request is accepted the cycle after the last cell enters the
// output register, even while that cell still waits to be taken.
// Reset (synchronous, active high) returns the controller to idle and drops rsp_valid.
`default_nettype none

module line_rasterizer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire lr_pkg::lr_req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lr_pkg::lr_rsp_type      rsp_data
);

   // Command and status between the controller and the datapath.
   lr_pkg::lr_cmd_type cmd;
   lr_pkg::lr_sts_type sts;

   // Sequence the handshakes; load at accept, emit one cell per free slot.
   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the walk state, advance the error term and the cell position.
   lr_dpath u_dpath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
